// ----- hdl/non_max_suppression_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the non-maximum suppression block
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef NON_MAX_SUPPRESSION_TOP_DEFINES_SVH
`define NON_MAX_SUPPRESSION_TOP_DEFINES_SVH

// same-cycle implication
`define NMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/nms_pkg.sv -----
// ---------------------------------------------------------------------------
// nms_pkg
// Types and constants shared by the non-maximum suppression block.
// ---------------------------------------------------------------------------
package nms_pkg;

    localparam int BOX_SLOTS = 64;
    localparam int IDX_W     = $clog2(BOX_SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CRD_W     = 18;
    localparam int DIFF_W    = CRD_W + 1;
    localparam int AREA_W    = 2 * DIFF_W;
    localparam int UNI_W     = AREA_W + 2;
    localparam int UL_W      = 20;
    localparam int UH_W      = UNI_W - 1 - UL_W;
    localparam int LIM_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER   = 3'd0,
        CFG_MAX_KEPT = 3'd1,
        CFG_OVERLAP  = 3'd2,
        CFG_FLOOR    = 3'd3,
        CFG_FLOOR_EN = 3'd4
    } nms_cfg_idx_t;

    typedef struct packed {
        logic [15:0]        batch_tag;
        logic [15:0]        class_tag;
        logic signed [15:0] coord_a;
        logic signed [15:0] coord_b;
        logic signed [15:0] coord_c;
        logic signed [15:0] coord_d;
        logic signed [15:0] score;
        logic               last_box;
    } nms_in_t;

    typedef struct packed {
        logic [15:0]      batch_out;
        logic [15:0]      class_out;
        logic [IDX_W-1:0] box_index;
        logic             none_selected;
        logic             overflow;
        logic             last_of_run;
    } nms_out_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] y1;
        logic signed [CRD_W-1:0] y2;
        logic signed [CRD_W-1:0] x1;
        logic signed [CRD_W-1:0] x2;
    } nms_box_t;

    typedef struct packed {
        logic signed [15:0] score;
        nms_box_t           box;
    } nms_rec_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        nms_box_t                 box;
        logic signed [AREA_W-1:0] area;
    } nms_kept_t;

    localparam int REC_W  = $bits(nms_rec_t);
    localparam int KEPT_W = $bits(nms_kept_t);

    typedef struct packed {
        logic               center_format;
        logic [6:0]         max_kept;
        logic [LIM_W-1:0]   overlap_limit;
        logic signed [15:0] score_floor;
        logic               score_floor_enable;
    } nms_cfg_t;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] box_count;
    } nms_sel_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] box_index;
        logic             none_selected;
        logic             last;
        logic             done;
    } nms_sel_sts_t;

endpackage

// ----- hdl/nms_ram.sv -----
// ---------------------------------------------------------------------------
// nms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/nms_engine.sv -----
// ---------------------------------------------------------------------------
// nms_engine
// Selection sequencer: repeated max-score scan over the box store, IoU check
// against the kept store, then read-out of the kept list.
// ---------------------------------------------------------------------------
`include "non_max_suppression_top_defines.svh"

module nms_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nms_pkg::nms_cfg_t           cfg,
    input  nms_pkg::nms_sel_ctl_t       ctl,
    output logic [nms_pkg::IDX_W-1:0]   box_raddr,
    input  logic [nms_pkg::REC_W-1:0]   box_rdata,
    output nms_pkg::nms_sel_sts_t       sts
);
    import nms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_FETCH, S_LOAD, S_AREA, S_CREAD, S_CDIFF,
        S_CMUL, S_CUNI, S_MLO, S_MHI, S_CMP, S_KEEP, S_EREAD, S_EOUT, S_NONE
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         limit_reg;
    logic [CNT_W-1:0]         kcnt_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [CNT_W-1:0]         scan_reg;
    logic                     cmp_vld_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     found_reg;
    logic signed [15:0]       best_score_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [BOX_SLOTS-1:0]     taken_reg;
    nms_box_t                 cand_box_reg;
    logic signed [DIFF_W-1:0] cand_dy_reg;
    logic signed [DIFF_W-1:0] cand_dx_reg;
    logic signed [AREA_W-1:0] cand_area_reg;
    logic signed [DIFF_W-1:0] ih_reg;
    logic signed [DIFF_W-1:0] iw_reg;
    logic signed [AREA_W-1:0] kept_area_reg;
    logic signed [AREA_W-1:0] inter_reg;
    logic signed [UNI_W-1:0]  uni_reg;
    logic [LIM_W+UL_W-1:0]    plo_reg;
    logic [LIM_W+UH_W-1:0]    phi_reg;

    nms_rec_t              rec;
    nms_kept_t             krec;
    logic [KEPT_W-1:0]     kept_rdata;
    logic                  kept_we;
    nms_kept_t             kept_wdata;
    logic                  elig;
    logic                  better;
    logic                  found_now;
    logic                  k_last;
    logic signed [CRD_W-1:0] iy1, iy2, ix1, ix2;
    logic [LIM_W+UL_W+UH_W:0] lhs;
    logic [LIM_W+UL_W+UH_W:0] rhs;
    logic [CNT_W-1:0]      limit_sat;

    assign rec       = nms_rec_t'(box_rdata);
    assign krec      = nms_kept_t'(kept_rdata);
    assign box_raddr = (state_reg == S_FETCH) ? best_idx_reg : scan_reg[IDX_W-1:0];

    assign kept_we    = (state_reg == S_KEEP);
    assign kept_wdata = '{idx: best_idx_reg, box: cand_box_reg, area: cand_area_reg};

    nms_ram #(.WIDTH(KEPT_W), .DEPTH(BOX_SLOTS)) u_kept_ram (
        .clk   (clk),
        .we    (kept_we),
        .waddr (kcnt_reg[IDX_W-1:0]),
        .wdata (kept_wdata),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (kept_rdata)
    );

    always_comb
    begin
        elig      = cmp_vld_reg && !taken_reg[cmp_idx_reg]
                    && (!cfg.score_floor_enable || (rec.score > cfg.score_floor));
        better    = elig && (!found_reg || (rec.score > best_score_reg));
        found_now = found_reg || elig;
        k_last    = ((k_reg + CNT_W'(1)) == kcnt_reg);
        iy1 = (cand_box_reg.y1 > krec.box.y1) ? cand_box_reg.y1 : krec.box.y1;
        iy2 = (cand_box_reg.y2 < krec.box.y2) ? cand_box_reg.y2 : krec.box.y2;
        ix1 = (cand_box_reg.x1 > krec.box.x1) ? cand_box_reg.x1 : krec.box.x1;
        ix2 = (cand_box_reg.x2 < krec.box.x2) ? cand_box_reg.x2 : krec.box.x2;
        lhs = {{(LIM_W+UL_W+UH_W+1-AREA_W-15){1'b0}}, inter_reg, 15'b0};
        rhs = {1'b0, phi_reg, {UL_W{1'b0}}} + {{(UH_W+1){1'b0}}, plo_reg};
        limit_sat = (cfg.max_kept > 7'(BOX_SLOTS)) ? CNT_W'(BOX_SLOTS)
                                                   : CNT_W'(cfg.max_kept);
    end

    always_comb
    begin
        sts.valid         = (state_reg == S_EOUT) || (state_reg == S_NONE);
        sts.none_selected = (state_reg == S_NONE);
        sts.box_index     = (state_reg == S_NONE) ? '0 : krec.idx;
        sts.last          = (state_reg == S_NONE) || k_last;
        sts.done          = sts.valid && sts.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            limit_reg      <= '0;
            kcnt_reg       <= '0;
            k_reg          <= '0;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            taken_reg      <= '0;
            cand_box_reg   <= '0;
            cand_dy_reg    <= '0;
            cand_dx_reg    <= '0;
            cand_area_reg  <= '0;
            ih_reg         <= '0;
            iw_reg         <= '0;
            kept_area_reg  <= '0;
            inter_reg      <= '0;
            uni_reg        <= '0;
            plo_reg        <= '0;
            phi_reg        <= '0;
        end
        else
        begin
            if (better)
            begin
                found_reg      <= 1'b1;
                best_score_reg <= rec.score;
                best_idx_reg   <= cmp_idx_reg;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.go)
                    begin
                        limit_reg   <= limit_sat;
                        kcnt_reg    <= '0;
                        taken_reg   <= '0;
                        cnt_reg     <= ctl.box_count;
                        scan_reg    <= '0;
                        found_reg   <= 1'b0;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= (limit_sat == '0) ? S_NONE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    cmp_vld_reg <= 1'b1;
                    cmp_idx_reg <= scan_reg[IDX_W-1:0];
                    scan_reg    <= scan_reg + CNT_W'(1);
                    if ((scan_reg + CNT_W'(1)) == cnt_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    cmp_vld_reg <= 1'b0;
                    k_reg       <= '0;
                    if (found_now)
                    begin
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        state_reg <= (kcnt_reg == '0) ? S_NONE : S_EREAD;
                    end
                end
                S_FETCH:
                begin
                    taken_reg[best_idx_reg] <= 1'b1;
                    state_reg               <= S_LOAD;
                end
                S_LOAD:
                begin
                    cand_box_reg <= rec.box;
                    cand_dy_reg  <= DIFF_W'(rec.box.y2) - DIFF_W'(rec.box.y1);
                    cand_dx_reg  <= DIFF_W'(rec.box.x2) - DIFF_W'(rec.box.x1);
                    state_reg    <= S_AREA;
                end
                S_AREA:
                begin
                    cand_area_reg <= AREA_W'(cand_dy_reg) * AREA_W'(cand_dx_reg);
                    k_reg         <= '0;
                    state_reg     <= (kcnt_reg == '0) ? S_KEEP : S_CREAD;
                end
                S_CREAD:
                begin
                    state_reg <= S_CDIFF;
                end
                S_CDIFF:
                begin
                    ih_reg        <= DIFF_W'(iy2) - DIFF_W'(iy1);
                    iw_reg        <= DIFF_W'(ix2) - DIFF_W'(ix1);
                    kept_area_reg <= krec.area;
                    state_reg     <= S_CMUL;
                end
                S_CMUL:
                begin
                    if ((ih_reg <= 0) || (iw_reg <= 0))
                    begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= k_last ? S_KEEP : S_CREAD;
                    end
                    else
                    begin
                        inter_reg <= AREA_W'(ih_reg) * AREA_W'(iw_reg);
                        state_reg <= S_CUNI;
                    end
                end
                S_CUNI:
                begin
                    uni_reg   <= UNI_W'(cand_area_reg) + UNI_W'(kept_area_reg)
                                 - UNI_W'(inter_reg);
                    state_reg <= S_MLO;
                end
                S_MLO:
                begin
                    if (uni_reg <= 0)
                    begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= k_last ? S_KEEP : S_CREAD;
                    end
                    else
                    begin
                        plo_reg   <= (LIM_W+UL_W)'(cfg.overlap_limit)
                                     * (LIM_W+UL_W)'(uni_reg[UL_W-1:0]);
                        state_reg <= S_MHI;
                    end
                end
                S_MHI:
                begin
                    phi_reg   <= (LIM_W+UH_W)'(cfg.overlap_limit)
                                 * (LIM_W+UH_W)'(uni_reg[UNI_W-2:UL_W]);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (lhs > rhs)
                    begin
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= k_last ? S_KEEP : S_CREAD;
                    end
                end
                S_KEEP:
                begin
                    kcnt_reg <= kcnt_reg + CNT_W'(1);
                    k_reg    <= '0;
                    if ((kcnt_reg + CNT_W'(1)) == limit_reg)
                    begin
                        state_reg <= S_EREAD;
                    end
                    else
                    begin
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_EREAD:
                begin
                    state_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    k_reg     <= k_reg + CNT_W'(1);
                    state_reg <= k_last ? S_IDLE : S_EREAD;
                end
                S_NONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `NMS_ASSERT_IMP(a_strobe_state, sts.valid, (state_reg == S_EOUT) || (state_reg == S_NONE), "strobe outside read-out")
    `NMS_ASSERT_IMP(a_kept_bound, state_reg != S_IDLE, kcnt_reg <= limit_reg, "kept count above bound")
    `NMS_ASSERT_NXT(a_done_idle, sts.done, state_reg == S_IDLE, "run did not end after last result")

endmodule

// ----- hdl/non_max_suppression_top.sv -----
// Sequence: the last box request starts selection; each pick scans all N stored boxes
// and checks it against the K boxes kept so far, then the kept list is read out, each result
// fetched in S_EREAD and presented in S_EOUT.
// Throughput: one box request per cycle while loading; busy stays high during selection.
// Reset: asynchronous, all control state and registers cleared; stores need no clearing.
// Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// non_max_suppression_top
// Greedy IoU-based non-maximum suppression over one run of boxes.
// ---------------------------------------------------------------------------
module non_max_suppression_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  nms_pkg::nms_in_t                item,
    output logic                            result_valid,
    output nms_pkg::nms_out_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nms_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import nms_pkg::*;

    nms_cfg_t          cfg_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic              busy_reg;
    logic [15:0]       batch_reg;
    logic [15:0]       class_reg;

    logic              accept;
    logic              room;
    logic [CNT_W-1:0]  count_next;
    nms_box_t          cbox;
    nms_rec_t          wrec;
    logic signed [CRD_W-1:0] ta, tb, tc, td;
    logic [IDX_W-1:0]  box_raddr;
    logic [REC_W-1:0]  box_rdata;
    nms_sel_ctl_t      ctl;
    nms_sel_sts_t      sts;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign accept    = start && !busy_reg;
    assign room      = (count_reg < CNT_W'(BOX_SLOTS));
    assign count_next = room ? (count_reg + CNT_W'(1)) : count_reg;

    always_comb
    begin
        ta = CRD_W'(item.coord_a) <<< 1;
        tb = CRD_W'(item.coord_b) <<< 1;
        tc = CRD_W'(item.coord_c);
        td = CRD_W'(item.coord_d);
        if (cfg_reg.center_format)
        begin
            cbox.y1 = tb - td;
            cbox.y2 = tb + td;
            cbox.x1 = ta - tc;
            cbox.x2 = ta + tc;
        end
        else
        begin
            cbox.y1 = (ta > (tc <<< 1)) ? (tc <<< 1) : ta;
            cbox.y2 = (ta > (tc <<< 1)) ? ta : (tc <<< 1);
            cbox.x1 = (tb > (td <<< 1)) ? (td <<< 1) : tb;
            cbox.x2 = (tb > (td <<< 1)) ? tb : (td <<< 1);
        end
        wrec.score = item.score;
        wrec.box   = cbox;
    end

    assign ctl.go        = accept && item.last_box;
    assign ctl.box_count = count_next;

    nms_ram #(.WIDTH(REC_W), .DEPTH(BOX_SLOTS)) u_box_ram (
        .clk   (clk),
        .we    (accept && room),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wrec),
        .raddr (box_raddr),
        .rdata (box_rdata)
    );

    nms_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .box_raddr (box_raddr),
        .box_rdata (box_rdata),
        .sts       (sts)
    );

    assign result_valid         = sts.valid;
    assign result.batch_out     = batch_reg;
    assign result.class_out     = class_reg;
    assign result.box_index     = sts.box_index;
    assign result.none_selected = sts.none_selected;
    assign result.overflow      = ovf_reg;
    assign result.last_of_run   = sts.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_format      <= 1'b0;
            cfg_reg.max_kept           <= '0;
            cfg_reg.overlap_limit      <= '0;
            cfg_reg.score_floor        <= 16'sh8000;
            cfg_reg.score_floor_enable <= 1'b0;
            count_reg                  <= '0;
            ovf_reg                    <= 1'b0;
            busy_reg                   <= 1'b0;
            batch_reg                  <= '0;
            class_reg                  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CENTER:   cfg_reg.center_format      <= cfg_data[0];
                    CFG_MAX_KEPT: cfg_reg.max_kept           <= cfg_data[6:0];
                    CFG_OVERLAP:  cfg_reg.overlap_limit      <= cfg_data;
                    CFG_FLOOR:    cfg_reg.score_floor        <= cfg_data;
                    CFG_FLOOR_EN: cfg_reg.score_floor_enable <= cfg_data[0];
                    default:      ;
                endcase
            end
            if (accept)
            begin
                if ((count_reg == '0) && !ovf_reg)
                begin
                    batch_reg <= item.batch_tag;
                    class_reg <= item.class_tag;
                end
                count_reg <= count_next;
                if (!room)
                begin
                    ovf_reg <= 1'b1;
                end
                if (item.last_box)
                begin
                    busy_reg <= 1'b1;
                end
            end
            if (sts.done)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                busy_reg  <= 1'b0;
            end
        end
    end

endmodule
